// ===== sv/mkte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the key character table for the multi-tap keypad core.
// No dependencies; mkte_ctrl, mkte_dp and the top-level core import this package.
package mkte_pkg;

  localparam int CHAR_W         = 8;
  localparam int TEXT_DEPTH_DEF = 128;
  localparam int TICK_W         = 16;
  localparam int POS_OUT_W      = 7;
  localparam int IN_TDATA_W     = 16;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd499;
  localparam logic [TICK_W-1:0] TICK_SAT      = 16'hFFFF;
  localparam logic [2:0]        NO_KEY        = 3'd5;
  localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;

  // func codes
  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // column 3 holds the edit keys
  localparam logic [1:0] COL_EDIT  = 2'd3;
  localparam logic [1:0] ROW_BKSP  = 2'd0;
  localparam logic [1:0] ROW_LEFT  = 2'd1;
  localparam logic [1:0] ROW_RIGHT = 2'd2;
  localparam logic [1:0] ROW_CLEAR = 2'd3;

  // indexed by {tap, row, col}; column 3 entries are never used
  localparam logic [CHAR_W-1:0] CHAR_TABLE [0:63] = '{
    "1", "A", "D", "1",  "G", "J", "M", "G",  "P", "T", "W", "P",  "*", "0", "#", "*",
    "1", "B", "E", "1",  "H", "K", "N", "H",  "R", "U", "X", "R",  "*", " ", ".", "*",
    "1", "C", "F", "1",  "I", "L", "O", "I",  "S", "V", "Y", "S",  "*", "0", "?", "*",
    "1", "2", "3", "1",  "4", "5", "6", "4",  "7", "8", "9", "7",  "*", " ", "!", "*"
  };

  typedef struct packed {
    logic accept;      // request taken this cycle, update scalar state
    logic clear_wr;    // write a space at the sweep pointer
    logic shift_rd;    // prime the first read of a backspace shift
    logic shift_wr;    // move one cell down, read the next
    logic shift_last;  // write a space into the top cell
    logic read_cap;    // capture buffer read data
    logic load_out;    // load the result register
  } mkte_cmd_t;

  typedef struct packed {
    logic need_clear;
    logic need_shift;
    logic need_read;
    logic ptr_end;     // pointer on the top cell
    logic ptr_pen;     // pointer one below the top cell
    logic out_free;
  } mkte_status_t;

endpackage

// ===== sv/mkte_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mkte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mkte_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the keypad core: accepts requests, runs clear sweeps, backspace shifts,
// buffer reads and result hand-off. Depends on mkte_pkg.
module mkte_ctrl import mkte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  mkte_status_t status,
  output mkte_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_CLEAR      = 7'b0000010,
    ST_SHIFT_RD   = 7'b0000100,
    ST_SHIFT      = 7'b0001000,
    ST_SHIFT_LAST = 7'b0010000,
    ST_READ       = 7'b0100000,
    ST_DONE       = 7'b1000000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       owe_r, owe_nxt;   // a result is owed for the current request

  always_comb begin
    state_nxt = state_r;
    owe_nxt   = owe_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          owe_nxt    = 1'b1;
          if (status.need_clear) begin
            state_nxt = ST_CLEAR;
          end else if (status.need_shift) begin
            state_nxt = ST_SHIFT_RD;
          end else if (status.need_read) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.ptr_end) begin
          state_nxt = owe_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (status.ptr_pen) begin
          state_nxt = ST_SHIFT_LAST;
        end
      end
      ST_SHIFT_LAST: begin
        cmd.shift_last = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_READ: begin
        cmd.read_cap = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          owe_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        owe_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      owe_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      owe_r   <= owe_nxt;
    end
  end

endmodule

// ===== sv/mkte_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the keypad core: edit state, multi-tap logic, timer, text buffer RAM,
// sweep pointer and result register. Depends on mkte_pkg and mkte_ram.
module mkte_dp import mkte_pkg::*; #(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             func,
  input  logic [1:0]             key_row,
  input  logic [1:0]             key_col,
  input  logic [6:0]             read_index,
  input  logic                   cfg_we,
  input  logic [TICK_W-1:0]      cfg_data,
  input  mkte_cmd_t              cmd,
  output mkte_status_t           status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(TEXT_DEPTH - 1);
  localparam logic [AW-1:0] PEN_ADDR = AW'(TEXT_DEPTH - 2);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(TEXT_DEPTH);

  logic [AW-1:0]     cur_r, cur_nxt, len_r, len_nxt, ptr_r, ptr_nxt;
  logic [2:0]        hrow_r, hrow_nxt, hcol_r, hcol_nxt;
  logic [1:0]        tap_r, tap_nxt;
  logic [CHAR_W-1:0] pend_r, pend_nxt;
  logic              prev_r, prev_nxt, trun_r, trun_nxt;
  logic [TICK_W-1:0] tcnt_r, tcnt_nxt, ticks_r, tcnt_inc;
  logic              rc_ok_r;
  logic [CHAR_W-1:0] rchar_r;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // RAM ports
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;

  // commit of the pending character, evaluated from the state before the request
  logic              cm_wr;
  logic [AW-1:0]     cm_cur, cm_len;
  logic              same_key;
  logic [AW+6:0]     idx_ext;
  logic              idx_ok;

  function automatic logic [OUT_TDATA_W-1:0] build_result(
    input logic [AW-1:0]     cur,
    input logic [AW-1:0]     len,
    input logic              prev,
    input logic [CHAR_W-1:0] pend,
    input logic [CHAR_W-1:0] rchar
  );
    logic [AW+6:0] cur_x;
    logic [AW+6:0] len_x;
    cur_x = {{POS_OUT_W{1'b0}}, cur};
    len_x = {{POS_OUT_W{1'b0}}, len};
    return {1'b0, (prev ? pend : {CHAR_W{1'b0}}), prev,
            len_x[POS_OUT_W-1:0], cur_x[POS_OUT_W-1:0], rchar};
  endfunction

  assign idx_ext  = {{AW{1'b0}}, read_index};
  assign idx_ok   = idx_ext < (AW+7)'(TEXT_DEPTH);
  assign cm_wr    = prev_r && (({1'b0, cur_r} + 1'b1) < DEPTH_X);
  assign cm_cur   = cm_wr ? cur_r + 1'b1 : cur_r;
  assign cm_len   = (cm_wr && (len_r < cm_cur)) ? cm_cur : len_r;
  assign same_key = prev_r && (hrow_r == {1'b0, key_row}) && (hcol_r == {1'b0, key_col});
  assign tcnt_inc = (tcnt_r != TICK_SAT) ? tcnt_r + 1'b1 : tcnt_r;

  assign status.need_read  = (func == FUNC_READ);
  assign status.need_clear = (func == FUNC_KEY) && (key_col == COL_EDIT)
                             && (key_row == ROW_CLEAR);
  assign status.need_shift = (func == FUNC_KEY) && (key_col == COL_EDIT)
                             && (key_row == ROW_BKSP) && !prev_r && (cur_r != '0);
  assign status.ptr_end    = (ptr_r == TOP_ADDR);
  assign status.ptr_pen    = (ptr_r == PEN_ADDR);
  assign status.out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    cur_nxt  = cur_r;
    len_nxt  = len_r;
    ptr_nxt  = ptr_r;
    hrow_nxt = hrow_r;
    hcol_nxt = hcol_r;
    tap_nxt  = tap_r;
    pend_nxt = pend_r;
    prev_nxt = prev_r;
    tcnt_nxt = tcnt_r;
    trun_nxt = trun_r;
    we       = 1'b0;
    waddr    = cur_r;
    wdata    = pend_r;
    raddr    = idx_ext[AW-1:0];

    if (cmd.accept) begin
      case (func)
        FUNC_KEY: begin
          trun_nxt = 1'b0;
          tcnt_nxt = '0;
          // any path other than a repeat tap drops the pending character
          prev_nxt = 1'b0;
          pend_nxt = '0;
          hrow_nxt = NO_KEY;
          hcol_nxt = NO_KEY;
          tap_nxt  = '0;
          if (key_col == COL_EDIT) begin
            case (key_row)
              ROW_BKSP: begin
                if (status.need_shift) begin
                  cur_nxt = cur_r - 1'b1;
                  ptr_nxt = cur_r - 1'b1;
                  if (len_r != '0) begin
                    len_nxt = len_r - 1'b1;
                  end
                end
              end
              ROW_LEFT: begin
                we      = cm_wr;
                len_nxt = cm_len;
                cur_nxt = (cm_cur != '0) ? cm_cur - 1'b1 : cm_cur;
              end
              ROW_RIGHT: begin
                we      = cm_wr;
                len_nxt = cm_len;
                cur_nxt = (cm_cur < cm_len) ? cm_cur + 1'b1 : cm_cur;
              end
              default: begin
                cur_nxt = '0;
                len_nxt = '0;
                ptr_nxt = '0;
              end
            endcase
          end else begin
            if (same_key) begin
              tap_nxt = tap_r + 1'b1;
            end else begin
              we      = cm_wr;
              cur_nxt = cm_cur;
              len_nxt = cm_len;
              tap_nxt = '0;
            end
            hrow_nxt = {1'b0, key_row};
            hcol_nxt = {1'b0, key_col};
            pend_nxt = CHAR_TABLE[{tap_nxt, key_row, key_col}];
            prev_nxt = 1'b1;
            trun_nxt = 1'b1;
          end
        end
        FUNC_TICK: begin
          if (trun_r) begin
            if (tcnt_inc >= ticks_r) begin
              trun_nxt = 1'b0;
              tcnt_nxt = '0;
              we       = cm_wr;
              cur_nxt  = cm_cur;
              len_nxt  = cm_len;
              prev_nxt = 1'b0;
              pend_nxt = '0;
              hrow_nxt = NO_KEY;
              hcol_nxt = NO_KEY;
              tap_nxt  = '0;
            end else begin
              tcnt_nxt = tcnt_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.clear_wr) begin
      we      = 1'b1;
      waddr   = ptr_r;
      wdata   = SPACE_CHAR;
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.shift_rd) begin
      raddr = ptr_r + 1'b1;
    end else if (cmd.shift_wr) begin
      we      = 1'b1;
      waddr   = ptr_r;
      wdata   = rdata;
      raddr   = ptr_r + AW'(2);
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.shift_last) begin
      we    = 1'b1;
      waddr = TOP_ADDR;
      wdata = SPACE_CHAR;
    end
  end

  mkte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      len_r   <= '0;
      ptr_r   <= '0;
      hrow_r  <= NO_KEY;
      hcol_r  <= NO_KEY;
      tap_r   <= '0;
      pend_r  <= '0;
      prev_r  <= 1'b0;
      tcnt_r  <= '0;
      trun_r  <= 1'b0;
      ticks_r <= TIMEOUT_RESET;
    end else begin
      cur_r  <= cur_nxt;
      len_r  <= len_nxt;
      ptr_r  <= ptr_nxt;
      hrow_r <= hrow_nxt;
      hcol_r <= hcol_nxt;
      tap_r  <= tap_nxt;
      pend_r <= pend_nxt;
      prev_r <= prev_nxt;
      tcnt_r <= tcnt_nxt;
      trun_r <= trun_nxt;
      if (cfg_we) begin
        ticks_r <= cfg_data;
      end
    end
  end

  // read data and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rc_ok_r <= status.need_read && idx_ok;
      rchar_r <= '0;
    end else if (cmd.read_cap) begin
      rchar_r <= rc_ok_r ? rdata : '0;
    end
    if (cmd.load_out) begin
      out_tdata_r <= build_result(cur_r, len_r, prev_r, pend_r, rchar_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/multitap_keypad_text_entry_core.sv =====
`timescale 1ns / 1ps
// Multi-tap keypad text entry core. A request goes from IDLE to DONE, via CLEAR for a
// clear, SHIFT_RD, SHIFT and SHIFT_LAST for a backspace that shifts, or READ for a read;
// DONE loads the result once the output register is free. Clear and the shift walk the
// text RAM one cell per cycle. One request at a time; in_tready is high only in IDLE.
// Reset (rst_n, synchronous, active low) clears the edit state and then sweeps the text
// RAM to spaces with in_tready low; config writes are still taken.
module multitap_keypad_text_entry_core import mkte_pkg::*; #(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request: tdata {read_index[10:4], key_col[3:2], key_row[1:0]} highest field first
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: func[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // result: tdata read_char[7:0], cursor[14:8], text_length[21:15],
  //         preview_active[22], preview_char[30:23], bit 31 zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // timeout_ticks register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TICK_W-1:0]      cfg_data
);

  mkte_cmd_t    cmd;
  mkte_status_t status;

  // writable out of reset; user keeps the block idle when it is written (not enforced)
  assign cfg_ready = rst_n;

  mkte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the edit state, timer, text RAM and result register
  mkte_dp #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .func       (in_tuser[1:0]),
    .key_row    (in_tdata[1:0]),
    .key_col    (in_tdata[3:2]),
    .read_index (in_tdata[10:4]),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // one request in flight: after a request is taken the input closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another was in flight");

  // reset always starts the RAM sweep with the input closed
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open right after reset");

  // cursor never passes the text length
  a_cursor_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    (TEXT_DEPTH <= 128) && out_tvalid |-> (out_tdata[14:8] <= out_tdata[21:15]))
    else $error("cursor beyond text length");

  // preview character shows only while a preview is active
  a_preview_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[22] |-> (out_tdata[30:23] == '0))
    else $error("preview character without active preview");

endmodule
